// File: sv/lobm_pkg.sv
// Package for the limit order book matcher: widths, event codes, command and status types.
// Used by lobm_ctrl, lobm_datapath and limit_order_book_matcher.
package lobm_pkg;
   localparam int PriceLevels = 64;
   localparam int LevelDepth  = 16;
   localparam int MaxFills    = 62;
   localparam int TickW   = $clog2(PriceLevels);
   localparam int PosW    = $clog2(LevelDepth);
   localparam int CountW  = $clog2(LevelDepth + 1);
   localparam int FillW   = $clog2(MaxFills + 1);
   localparam int AddrW   = TickW + PosW;
   localparam int VolW    = 24;
   localparam int IdW     = 32;
   localparam int SlotW   = IdW + VolW;
   // Level table entry holds the FIFO head and count; bids and asks share one table.
   localparam int LvW     = PosW + CountW;
   localparam int LvAddrW = TickW + 1;

   localparam logic [2:0] EV_TRADE    = 3'd0;
   localparam logic [2:0] EV_RESTED   = 3'd1;
   localparam logic [2:0] EV_PARTIAL  = 3'd2;
   localparam logic [2:0] EV_RETURNED = 3'd3;
   localparam logic [2:0] EV_FULL     = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture a new request
      logic scan;       // register best level of the opposite side
      logic own;        // point the level table read at the request's own level
      logic clear;      // clear one level table entry after reset
      logic trade;      // apply the read slot, emit a trade
      logic status;     // emit the final status, resting if it applies
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic zero_vol;
      logic crossable;  // registered best level exists and crosses the limit or order is market
      logic fills_max;
      logic rem_zero;
      logic clr_done;   // last level table entry is being cleared
   } stat_type;
endpackage

// File: sv/lobm_ram.sv
// Generic RAM with one write port, one read port and registered read.
// Depends on nothing.
module lobm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: sv/lobm_ctrl.sv
// Controller state machine of the matcher: sequences scan, read, trade and status steps.
// Depends on lobm_pkg.
module lobm_ctrl import lobm_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     out_valid,
   input  logic     out_stall,
   input  stat_type st,
   output cmd_type  cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_DEC   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_TRADE = 3'd4;
   localparam logic [2:0] S_STAT  = 3'd5;
   localparam logic [2:0] S_WAIT  = 3'd6;
   localparam logic [2:0] S_CLR   = 3'd7;

   logic [2:0] state_ff, state_in;

   // The output register is free when it is empty or being taken now.
   logic free;
   assign free = !out_valid || !out_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clear = 1'b1;
            if (st.clr_done) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            if (!st.zero_vol && st.crossable && !st.fills_max) state_in = S_READ;
            else begin
               // The own level entry is read here, ahead of the status step.
               cmd.own  = 1'b1;
               state_in = S_STAT;
            end
         end
         S_READ: state_in = S_TRADE;
         S_TRADE: if (free) begin
            cmd.trade = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            // Trade result is in the output register; check remainder.
            if (st.rem_zero) state_in = S_IDLE;
            else begin
               cmd.scan = 1'b1;
               state_in = S_DEC;
            end
         end
         S_STAT: begin
            cmd.own = 1'b1;
            if (free) begin
               cmd.status = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         out_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.trade || cmd.status) out_valid <= 1'b1;
         else if (!out_stall) out_valid <= 1'b0;
      end
   end
endmodule

// File: sv/lobm_datapath.sv
// Datapath of the matcher: book state, slot memories, level scan and result register.
// Depends on lobm_pkg and lobm_ram.
module lobm_datapath import lobm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          st,
   input  logic [IdW-1:0]    req_order_ident,
   input  logic              req_order_side,
   input  logic              req_order_kind,
   input  logic [5:0]        req_price_tick,
   input  logic [VolW-1:0]   req_order_volume,
   output logic [2:0]        rsp_event_kind,
   output logic [IdW-1:0]    rsp_taker_ident,
   output logic [IdW-1:0]    rsp_maker_ident,
   output logic [5:0]        rsp_fill_tick,
   output logic [VolW-1:0]   rsp_fill_volume,
   output logic [VolW-1:0]   rsp_taker_remaining,
   output logic              rsp_last_event
);
   logic [IdW-1:0]   ident_ff;
   logic             sell_ff, market_ff;
   logic [TickW-1:0] tick_ff;
   logic [VolW-1:0]  rem_ff;
   logic [FillW-1:0] fills_ff;
   logic [TickW-1:0] lvl_ff;
   logic             found_ff;
   logic [LvAddrW-1:0] clr_ff;
   logic [PriceLevels-1:0] bid_occ_ff, ask_occ_ff;

   // Tick saturation at the highest level, PriceLevels - 1.
   logic [TickW-1:0] tick_sat;
   always_comb begin
      if ({1'b0, req_price_tick} >= 7'(PriceLevels)) tick_sat = TickW'(PriceLevels - 1);
      else tick_sat = TickW'(req_price_tick);
   end

   // Best level: lowest ask for a buy, highest bid for a sell.
   logic [TickW-1:0] best_lo, best_hi, best_new;
   logic             any_bid, any_ask;
   always_comb begin
      best_lo = '0;
      best_hi = '0;
      for (int i = PriceLevels - 1; i >= 0; i--)
         if (ask_occ_ff[i]) best_lo = TickW'(i);
      for (int i = 0; i < PriceLevels; i++)
         if (bid_occ_ff[i]) best_hi = TickW'(i);
      any_bid = |bid_occ_ff;
      any_ask = |ask_occ_ff;
   end
   assign best_new = sell_ff ? best_hi : best_lo;

   logic crosses;
   assign crosses = found_ff && (market_ff ||
                    (!sell_ff && lvl_ff <= tick_ff) || (sell_ff && lvl_ff >= tick_ff));
   assign st.zero_vol  = (rem_ff == '0);
   assign st.crossable = crosses;
   assign st.fills_max = (fills_ff >= FillW'(MaxFills));
   assign st.rem_zero  = (rem_ff == '0);
   assign st.clr_done  = (clr_ff == '1);

   // Level table: bids in the lower half, asks in the upper half.
   logic [LvAddrW-1:0] lv_raddr, lv_waddr;
   logic [LvW-1:0]     lv_rdata, lv_wdata;
   logic               lv_wr;
   logic [PosW-1:0]    lv_head;
   logic [CountW-1:0]  lv_cnt;
   logic               own_full;

   always_comb begin
      if (cmd.scan) lv_raddr = {!sell_ff, best_new};
      else if (cmd.own) lv_raddr = {sell_ff, tick_ff};
      else lv_raddr = {!sell_ff, lvl_ff};
   end
   assign lv_head  = lv_rdata[LvW-1:CountW];
   assign lv_cnt   = lv_rdata[CountW-1:0];
   assign own_full = (lv_cnt >= CountW'(LevelDepth));

   logic [SlotW-1:0] rd_bid, rd_ask, rd_slot;
   logic [AddrW-1:0] rd_addr, wr_addr, rest_addr;
   logic [SlotW-1:0] wr_data;
   logic             wr_bid, wr_ask;
   logic [VolW-1:0]  mvol, fill;
   logic             rest, consume;
   logic             found_or_block;

   assign rd_addr        = {lvl_ff, lv_head};
   assign rest_addr      = {tick_ff, PosW'(lv_head + PosW'(lv_cnt))};
   assign rd_slot        = sell_ff ? rd_bid : rd_ask;
   assign mvol           = rd_slot[SlotW-1:IdW];
   assign fill           = (mvol < rem_ff) ? mvol : rem_ff;
   assign consume        = cmd.trade && (mvol == fill);
   assign found_or_block = crosses && st.fills_max;
   assign rest = cmd.status && !st.zero_vol && !found_or_block && !market_ff && !own_full;

   always_comb begin
      wr_addr = rd_addr;
      wr_data = {mvol - fill, rd_slot[IdW-1:0]};
      wr_bid  = 1'b0;
      wr_ask  = 1'b0;
      if (cmd.trade && mvol != fill) begin
         wr_bid = sell_ff;
         wr_ask = !sell_ff;
      end else if (rest) begin
         wr_addr = rest_addr;
         wr_data = {rem_ff, ident_ff};
         wr_bid  = !sell_ff;
         wr_ask  = sell_ff;
      end
   end

   always_comb begin
      lv_wr    = 1'b0;
      lv_waddr = {!sell_ff, lvl_ff};
      lv_wdata = {PosW'(lv_head + 1'b1), CountW'(lv_cnt - 1'b1)};
      if (cmd.clear) begin
         lv_wr    = 1'b1;
         lv_waddr = clr_ff;
         lv_wdata = '0;
      end else if (consume) begin
         lv_wr = 1'b1;
      end else if (rest) begin
         lv_wr    = 1'b1;
         lv_waddr = {sell_ff, tick_ff};
         lv_wdata = {lv_head, CountW'(lv_cnt + 1'b1)};
      end
   end

   lobm_ram #(.Width(LvW), .Depth(2 * PriceLevels)) u_level (
      .clock(clock), .wr_en(lv_wr), .wr_addr(lv_waddr), .wr_data(lv_wdata),
      .rd_addr(lv_raddr), .rd_data(lv_rdata));
   lobm_ram #(.Width(SlotW), .Depth(PriceLevels * LevelDepth)) u_bid (
      .clock(clock), .wr_en(wr_bid), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_bid));
   lobm_ram #(.Width(SlotW), .Depth(PriceLevels * LevelDepth)) u_ask (
      .clock(clock), .wr_en(wr_ask), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_ask));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ident_ff  <= req_order_ident;
         sell_ff   <= req_order_side;
         market_ff <= req_order_kind;
         tick_ff   <= tick_sat;
         rem_ff    <= req_order_volume;
      end
      if (cmd.scan) begin
         lvl_ff   <= best_new;
         found_ff <= sell_ff ? any_bid : any_ask;
      end
      if (cmd.trade) begin
         rem_ff              <= rem_ff - fill;
         rsp_event_kind      <= EV_TRADE;
         rsp_taker_ident     <= ident_ff;
         rsp_maker_ident     <= rd_slot[IdW-1:0];
         rsp_fill_tick       <= 6'(lvl_ff);
         rsp_fill_volume     <= fill;
         rsp_taker_remaining <= rem_ff - fill;
         rsp_last_event      <= (rem_ff == fill);
      end
      if (cmd.status) begin
         rsp_taker_ident     <= ident_ff;
         rsp_maker_ident     <= '0;
         rsp_fill_volume     <= '0;
         rsp_taker_remaining <= rem_ff;
         rsp_last_event      <= 1'b1;
         rsp_fill_tick       <= market_ff ? 6'd0 : 6'(tick_ff);
         if (st.zero_vol) rsp_event_kind <= EV_RETURNED;
         else if (found_or_block) rsp_event_kind <= EV_FULL;
         else if (market_ff) rsp_event_kind <= EV_RETURNED;
         else if (own_full) rsp_event_kind <= EV_FULL;
         else rsp_event_kind <= (fills_ff != '0) ? EV_PARTIAL : EV_RESTED;
      end
   end

   // Occupancy, fill counter and the clearing pass over the level table.
   always_ff @(posedge clock) begin
      if (reset) begin
         bid_occ_ff <= '0;
         ask_occ_ff <= '0;
         fills_ff   <= '0;
         clr_ff     <= '0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.load) fills_ff <= '0;
         if (cmd.trade) fills_ff <= fills_ff + 1'b1;
         if (consume && lv_cnt == CountW'(1)) begin
            if (sell_ff) bid_occ_ff[lvl_ff] <= 1'b0;
            else ask_occ_ff[lvl_ff] <= 1'b0;
         end
         if (rest) begin
            if (sell_ff) ask_occ_ff[tick_ff] <= 1'b1;
            else bid_occ_ff[tick_ff] <= 1'b1;
         end
      end
   end
endmodule

// File: sv/limit_order_book_matcher.sv
// Top level of the limit order book matcher: controller, datapath and checks.
// Depends on lobm_pkg, lobm_ctrl and lobm_datapath.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  ident, side, kind, tick, volume
//   rsp_      out        rsp_valid/rsp_stall  event, idents, tick, volumes, last
//
// A request without trades steps through idle, scan, decide and status
// before the next accept. Each trade adds the steps decide, slot
// memory read, apply, and a rescan of the best level. The sequencer holds
// one request at a time; req_stall is high until the last result of a
// request is in the output register. Reset is synchronous; after it a
// pass over all 128 level table entries clears them while req_stall stays
// high, and slot memories are not cleared. A stalled result holds the
// sequencer in its emit step.
module limit_order_book_matcher import lobm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [31:0]     req_order_ident,
   input  logic            req_order_side,
   input  logic            req_order_kind,
   input  logic [5:0]      req_price_tick,
   input  logic [23:0]     req_order_volume,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [2:0]      rsp_event_kind,
   output logic [31:0]     rsp_taker_ident,
   output logic [31:0]     rsp_maker_ident,
   output logic [5:0]      rsp_fill_tick,
   output logic [23:0]     rsp_fill_volume,
   output logic [23:0]     rsp_taker_remaining,
   output logic            rsp_last_event
);
   cmd_type  cmd;
   stat_type st;

   lobm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .st(st), .cmd(cmd));

   lobm_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .st(st),
      .req_order_ident(req_order_ident), .req_order_side(req_order_side),
      .req_order_kind(req_order_kind), .req_price_tick(req_price_tick),
      .req_order_volume(req_order_volume),
      .rsp_event_kind(rsp_event_kind), .rsp_taker_ident(rsp_taker_ident),
      .rsp_maker_ident(rsp_maker_ident), .rsp_fill_tick(rsp_fill_tick),
      .rsp_fill_volume(rsp_fill_volume), .rsp_taker_remaining(rsp_taker_remaining),
      .rsp_last_event(rsp_last_event));

   // A trade never carries zero volume.
   a_no_zero_trade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_TRADE |-> rsp_fill_volume != '0)
      else $error("zero-volume trade");

   // Only one emit command at a time.
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      !(cmd.trade && cmd.status))
      else $error("trade and status together");

   // A status result always closes the request.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_TRADE |-> rsp_last_event)
      else $error("status without last flag");
endmodule
